>>> hdl/htrd_pkg.sv
// Shared types and constants for the tree-rebuilding Huffman decoder.
package htrd_pkg;

    // Field and table widths fixed by the node format.
    localparam int SYM_W    = 8;
    localparam int IDX_W    = 9;
    localparam int NODE_W   = 19;
    localparam int LEAF_BIT = 18;
    localparam int CNT_W    = 32;
    localparam int DATA_W   = 32;

    // Default alphabet size for the top-level parameter.
    localparam int MAX_SYMBOLS_DEF = 256;

    // Input item kinds.
    localparam logic OP_TREE = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Configuration register map (index taken from paddr[2]).
    localparam int   ADDR_W         = 3;
    localparam logic REG_OUT_LENGTH = 1'b0;

    // Input request payload.
    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] byte_in;
    } in_t;

    // Output request payload.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             done_res;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic next_bit;
        logic tree_step;
        logic rd_left;
        logic merge_push;
        logic root_load;
        logic walk_rd;
        logic walk_eval;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic complete;
        logic reading_leaf;
        logic cur_bit;
        logic last_bit;
        logic sd_zero;
        logic sd_one;
        logic cnt_reached;
        logic cur_leaf;
        logic ent_leaf;
        logic pend_valid;
        logic out_free;
    } stat_t;

endpackage

>>> hdl/htrd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module htrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/htrd_ctrl.sv
// Controller state machine that sequences tree building and decoding bit by bit.
module htrd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  htrd_pkg::in_t  in_data,
    input  htrd_pkg::stat_t stat,
    output htrd_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TBIT   = 3'd1;
    localparam logic [2:0] ST_MRD2   = 3'd2;
    localparam logic [2:0] ST_MPUSH  = 3'd3;
    localparam logic [2:0] ST_ROOT   = 3'd4;
    localparam logic [2:0] ST_DISSUE = 3'd5;
    localparam logic [2:0] ST_DEVAL  = 3'd6;
    localparam logic [2:0] ST_FLUSH  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next-state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.bad)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (in_data.op == htrd_pkg::OP_TREE)
                    begin
                        state_next = stat.complete ? ST_IDLE : ST_TBIT;
                    end
                    else
                    begin
                        state_next = stat.complete ? ST_DISSUE : ST_IDLE;
                    end
                end
            end
            ST_TBIT:
            begin
                if (stat.bad || stat.complete)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.tree_step = 1'b1;
                    if (!stat.reading_leaf && !stat.cur_bit)
                    begin
                        // A zero bit outside a leaf: finish, fail or merge.
                        if (stat.sd_one)
                        begin
                            state_next = ST_ROOT;
                        end
                        else if (stat.sd_zero)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_MRD2;
                        end
                    end
                    else
                    begin
                        cmd.next_bit = 1'b1;
                        state_next   = stat.last_bit ? ST_IDLE : ST_TBIT;
                    end
                end
            end
            ST_MRD2:
            begin
                cmd.rd_left = 1'b1;
                state_next  = ST_MPUSH;
            end
            ST_MPUSH:
            begin
                cmd.merge_push = 1'b1;
                cmd.next_bit   = 1'b1;
                state_next     = stat.last_bit ? ST_IDLE : ST_TBIT;
            end
            ST_ROOT:
            begin
                cmd.root_load = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DISSUE:
            begin
                if (stat.cnt_reached)
                begin
                    state_next = ST_FLUSH;
                end
                else if (stat.cur_leaf)
                begin
                    // Root is a leaf: the bit leads nowhere.
                    cmd.next_bit = 1'b1;
                    state_next   = stat.last_bit ? ST_FLUSH : ST_DISSUE;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = ST_DEVAL;
                end
            end
            ST_DEVAL:
            begin
                // Hold while a new symbol would need the busy output register.
                if (!(stat.ent_leaf && stat.pend_valid && !stat.out_free))
                begin
                    cmd.walk_eval = 1'b1;
                    cmd.next_bit  = 1'b1;
                    state_next    = stat.last_bit ? ST_FLUSH : ST_DISSUE;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/htrd_dp.sv
// Datapath: node table, build stack, walk registers, symbol hold and output register.
module htrd_dp #(
    parameter int MAX_SYMBOLS = htrd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  htrd_pkg::in_t                 in_data,
    input  htrd_pkg::cmd_t                cmd,
    output htrd_pkg::stat_t               stat,
    input  logic                          cfg_we,
    input  logic [htrd_pkg::CNT_W-1:0]    cfg_wdata,
    output logic [htrd_pkg::CNT_W-1:0]    out_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output htrd_pkg::out_t                out_data
);

    localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int NA_W       = $clog2(NODE_DEPTH);
    localparam int SA_W       = $clog2(MAX_SYMBOLS);
    localparam int SD_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W      = htrd_pkg::IDX_W;
    localparam int SYM_W      = htrd_pkg::SYM_W;
    localparam int NODE_W     = htrd_pkg::NODE_W;
    localparam int CNT_W      = htrd_pkg::CNT_W;

    // Control registers.
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [2:0]       leaf_cnt_reg, leaf_cnt_next;
    logic [SYM_W-1:0] leaf_bits_reg, leaf_bits_next;
    logic             reading_leaf_reg, reading_leaf_next;
    logic             complete_reg, complete_next;
    logic             bad_reg, bad_next;
    logic [SD_W-1:0]  sd_reg, sd_next;
    logic [IDX_W-1:0] nc_reg, nc_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic [CNT_W-1:0] out_length_reg, out_length_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers.
    logic [SYM_W-1:0]  byte_reg, byte_next;
    logic [IDX_W-1:0]  root_reg, root_next;
    logic [IDX_W-1:0]  right_reg, right_next;
    logic [NODE_W-1:0] cur_ent_reg, cur_ent_next;
    logic [NODE_W-1:0] root_ent_reg, root_ent_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              pend_done_reg, pend_done_next;
    htrd_pkg::out_t    out_data_reg, out_data_next;

    // Memory ports.
    logic              node_we, node_re;
    logic [IDX_W-1:0]  node_raddr;
    logic [NODE_W-1:0] node_wdata, node_rdata;
    logic              stk_we, stk_re;
    logic [SD_W-1:0]   stk_raddr;
    logic [IDX_W-1:0]  stk_rdata;

    // Push helper signals.
    logic              push_req;
    logic [SD_W-1:0]   push_sd;
    logic [NODE_W-1:0] push_entry;
    logic              push_full;

    logic              cur_bit;
    logic              out_free;
    logic [CNT_W-1:0]  emitted_inc;
    logic [IDX_W-1:0]  child;
    logic [SYM_W-1:0]  leaf_sym;

    assign cur_bit     = byte_reg[SYM_W-1];
    assign out_free    = !out_valid_reg || out_ready;
    assign emitted_inc = emitted_reg + CNT_W'(1);
    assign child       = cur_bit ? cur_ent_reg[IDX_W-1:0] : cur_ent_reg[2*IDX_W-1:IDX_W];
    assign leaf_sym    = {leaf_bits_reg[SYM_W-2:0], cur_bit};
    assign push_full   = (nc_reg >= IDX_W'(NODE_DEPTH)) || (push_sd >= SD_W'(MAX_SYMBOLS));

    // Next-state logic for all registers.
    always_comb
    begin
        bit_cnt_next      = bit_cnt_reg;
        leaf_cnt_next     = leaf_cnt_reg;
        leaf_bits_next    = leaf_bits_reg;
        reading_leaf_next = reading_leaf_reg;
        complete_next     = complete_reg;
        bad_next          = bad_reg;
        sd_next           = sd_reg;
        nc_next           = nc_reg;
        emitted_next      = emitted_reg;
        out_length_next   = out_length_reg;
        pend_valid_next   = pend_valid_reg;
        out_valid_next    = out_valid_reg;
        byte_next         = byte_reg;
        root_next         = root_reg;
        right_next        = right_reg;
        cur_ent_next      = cur_ent_reg;
        root_ent_next     = root_ent_reg;
        pend_sym_next     = pend_sym_reg;
        pend_done_next    = pend_done_reg;
        out_data_next     = out_data_reg;
        push_req          = 1'b0;
        push_sd           = sd_reg;
        push_entry        = '0;
        node_we           = 1'b0;
        node_wdata        = '0;
        node_re           = 1'b0;
        node_raddr        = '0;
        stk_we            = 1'b0;
        stk_re            = 1'b0;
        stk_raddr         = '0;

        // Byte capture and bit advance.
        if (cmd.load)
        begin
            byte_next    = in_data.byte_in;
            bit_cnt_next = '0;
        end
        if (cmd.next_bit)
        begin
            byte_next    = {byte_reg[SYM_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
        end

        // One tree bit: leaf symbol bits, leaf start, completion or merge start.
        if (cmd.tree_step)
        begin
            if (reading_leaf_reg)
            begin
                if (leaf_cnt_reg == 3'd7)
                begin
                    push_req          = 1'b1;
                    push_entry        = {1'b1, {(NODE_W-1-SYM_W){1'b0}}, leaf_sym};
                    reading_leaf_next = 1'b0;
                    leaf_cnt_next     = '0;
                    leaf_bits_next    = '0;
                end
                else
                begin
                    leaf_bits_next = leaf_sym;
                    leaf_cnt_next  = leaf_cnt_reg + 3'd1;
                end
            end
            else if (cur_bit)
            begin
                reading_leaf_next = 1'b1;
                leaf_cnt_next     = '0;
                leaf_bits_next    = '0;
            end
            else if (sd_reg == SD_W'(1))
            begin
                complete_next = 1'b1;
                node_re       = 1'b1;
                node_raddr    = root_reg;
            end
            else if (sd_reg == '0)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                stk_re    = 1'b1;
                stk_raddr = sd_reg - SD_W'(1);
            end
        end

        // Merge: take the right child, then fetch the left child.
        if (cmd.rd_left)
        begin
            right_next = stk_rdata;
            stk_re     = 1'b1;
            stk_raddr  = sd_reg - SD_W'(2);
        end
        if (cmd.merge_push)
        begin
            push_req   = 1'b1;
            push_sd    = sd_reg - SD_W'(2);
            push_entry = {1'b0, stk_rdata, right_reg};
            sd_next    = push_sd;
        end

        // Push a new node, or flag a bad tree when a store is full.
        if (push_req)
        begin
            if (push_full)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                node_we    = 1'b1;
                node_wdata = push_entry;
                stk_we     = 1'b1;
                sd_next    = push_sd + SD_W'(1);
                nc_next    = nc_reg + IDX_W'(1);
                if (push_sd == '0)
                begin
                    root_next = nc_reg;
                end
            end
        end

        // Root entry fetched after completion.
        if (cmd.root_load)
        begin
            cur_ent_next  = node_rdata;
            root_ent_next = node_rdata;
        end

        // Walk step: fetch the child, then emit or descend.
        if (cmd.walk_rd)
        begin
            node_re    = 1'b1;
            node_raddr = child;
        end

        // Output register drains when taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.walk_eval)
        begin
            if (node_rdata[htrd_pkg::LEAF_BIT])
            begin
                emitted_next = emitted_inc;
                if (pend_valid_reg)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.symbol   = pend_sym_reg;
                    out_data_next.last     = 1'b0;
                    out_data_next.done_res = pend_done_reg;
                end
                pend_valid_next = 1'b1;
                pend_sym_next   = node_rdata[SYM_W-1:0];
                pend_done_next  = (emitted_inc == out_length_reg);
                cur_ent_next    = root_ent_reg;
            end
            else
            begin
                cur_ent_next = node_rdata;
            end
        end

        // The held symbol is the last one of its byte.
        if (cmd.flush)
        begin
            out_valid_next         = 1'b1;
            out_data_next.symbol   = pend_sym_reg;
            out_data_next.last     = 1'b1;
            out_data_next.done_res = pend_done_reg;
            pend_valid_next        = 1'b0;
        end

        // Configuration write.
        if (cfg_we)
        begin
            out_length_next = cfg_wdata;
        end
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg      <= '0;
            leaf_cnt_reg     <= '0;
            leaf_bits_reg    <= '0;
            reading_leaf_reg <= 1'b0;
            complete_reg     <= 1'b0;
            bad_reg          <= 1'b0;
            sd_reg           <= '0;
            nc_reg           <= '0;
            emitted_reg      <= '0;
            out_length_reg   <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            bit_cnt_reg      <= bit_cnt_next;
            leaf_cnt_reg     <= leaf_cnt_next;
            leaf_bits_reg    <= leaf_bits_next;
            reading_leaf_reg <= reading_leaf_next;
            complete_reg     <= complete_next;
            bad_reg          <= bad_next;
            sd_reg           <= sd_next;
            nc_reg           <= nc_next;
            emitted_reg      <= emitted_next;
            out_length_reg   <= out_length_next;
            pend_valid_reg   <= pend_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        root_reg      <= root_next;
        right_reg     <= right_next;
        cur_ent_reg   <= cur_ent_next;
        root_ent_reg  <= root_ent_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_data_reg  <= out_data_next;
    end

    // Node table.
    htrd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (nc_reg[NA_W-1:0]),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr[NA_W-1:0]),
        .rdata (node_rdata)
    );

    // Build stack.
    htrd_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_SYMBOLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (push_sd[SA_W-1:0]),
        .wdata (nc_reg),
        .re    (stk_re),
        .raddr (stk_raddr[SA_W-1:0]),
        .rdata (stk_rdata)
    );

    // Status to the controller.
    always_comb
    begin
        stat.bad          = bad_reg;
        stat.complete     = complete_reg;
        stat.reading_leaf = reading_leaf_reg;
        stat.cur_bit      = cur_bit;
        stat.last_bit     = (bit_cnt_reg == 3'd7);
        stat.sd_zero      = (sd_reg == '0);
        stat.sd_one       = (sd_reg == SD_W'(1));
        stat.cnt_reached  = (emitted_reg >= out_length_reg);
        stat.cur_leaf     = cur_ent_reg[htrd_pkg::LEAF_BIT];
        stat.ent_leaf     = node_rdata[htrd_pkg::LEAF_BIT];
        stat.pend_valid   = pend_valid_reg;
        stat.out_free     = out_free;
    end

    assign out_length = out_length_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

endmodule

>>> hdl/huffman_tree_rebuild_and_decode_top.sv
// Top level of the tree-rebuilding Huffman decoder: APB register and channel ports.
//
// Usage: first send tree requests (op = 0) carrying a post-order tree description,
// then data requests (op = 1). Bits are taken most significant first. Each data
// byte yields zero to eight symbol requests on the output channel; last marks the
// final symbol of a byte and done_res the symbol that reaches out_length.
// out_length is written over the APB port while the block is idle.
// Sequence: a tree byte is accepted, then handled bit by bit in the bit state; a merge bit
// adds a stack-read step and a push step, because a merge reads the two stack entries
// one after the other through the stack's single read port. Completing the tree adds
// a step that fetches the root node. A data byte is accepted, then each bit takes a
// node-table read and a decision, and a final step releases the held symbol; the
// decision waits while a new symbol would need the busy output register.
// Reset clears the tree, the counters and out_length; the node table and stack
// need no clearing. A symbol is held back one step so that last can be set; when
// the receiver stalls, the output register holds its request and decoding stops
// before the next symbol, while in_ready stays low until the byte is finished.
module huffman_tree_rebuild_and_decode_top #(
    parameter int MAX_SYMBOLS = htrd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  htrd_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output htrd_pkg::out_t                out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htrd_pkg::ADDR_W-1:0]   paddr,
    input  logic [htrd_pkg::DATA_W-1:0]   pwdata,
    output logic [htrd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    htrd_pkg::cmd_t              cmd;
    htrd_pkg::stat_t             stat;
    logic                        cfg_we;
    logic [htrd_pkg::CNT_W-1:0]  out_length;

    // APB decode: a single register at index zero.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == htrd_pkg::REG_OUT_LENGTH);
    assign prdata = (paddr[2] == htrd_pkg::REG_OUT_LENGTH) ? out_length : '0;

    htrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .stat     (stat),
        .cmd      (cmd)
    );

    htrd_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata),
        .out_length (out_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

>>> bench/tb_huffman_tree_rebuild_and_decode_top.sv
// Self-checking bench for the tree-rebuilding Huffman decoder: builds one tree, then decodes.
`timescale 1ns / 1ps

module tb_huffman_tree_rebuild_and_decode_top;

    localparam int MAX_SYM      = htrd_pkg::MAX_SYMBOLS_DEF;
    localparam int NODE_DEPTH   = 2 * MAX_SYM - 1;
    localparam int TREE_LEAVES  = 11;
    localparam int SETTLE_WAIT  = 40;
    localparam int HOLD_STRETCH = 300;
    localparam int STALL_LIMIT  = 3000;

    // Byte addresses of the register slots; only slot zero holds a register.
    localparam logic [htrd_pkg::ADDR_W-1:0] ADDR_OUT_LENGTH =
        {htrd_pkg::REG_OUT_LENGTH, 2'b00};
    localparam logic [htrd_pkg::ADDR_W-1:0] ADDR_SPARE      =
        {~htrd_pkg::REG_OUT_LENGTH, 2'b00};

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    htrd_pkg::in_t               in_data;
    logic                        out_valid;
    logic                        out_ready;
    htrd_pkg::out_t              out_data;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [htrd_pkg::ADDR_W-1:0] paddr;
    logic [htrd_pkg::DATA_W-1:0] pwdata;
    logic [htrd_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    // Shadow copy of the decoder: rebuilds the tree and queues the symbols it should emit.
    class huffman_shadow;
        logic [htrd_pkg::NODE_W-1:0] node_mem [NODE_DEPTH];
        logic [htrd_pkg::IDX_W-1:0]  stack_mem [MAX_SYM];
        int unsigned                 stack_top;
        int unsigned                 nodes_used;
        logic [htrd_pkg::SYM_W-1:0]  leaf_sym;
        int unsigned                 leaf_cnt;
        bit                          in_leaf;
        bit                          complete;
        bit                          bad;
        logic [htrd_pkg::IDX_W-1:0]  walk;
        logic [htrd_pkg::CNT_W-1:0]  emitted;
        logic [htrd_pkg::CNT_W-1:0]  limit;
        htrd_pkg::out_t              pending [$];
        int                          errors;

        function new();
            foreach (node_mem[i]) node_mem[i] = '0;
            foreach (stack_mem[i]) stack_mem[i] = '0;
            stack_top  = 0;
            nodes_used = 0;
            leaf_sym   = '0;
            leaf_cnt   = 0;
            in_leaf    = 0;
            complete   = 0;
            bad        = 0;
            walk       = '0;
            emitted    = '0;
            limit      = '0;
            errors     = 0;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function logic [htrd_pkg::NODE_W-1:0] read_node(logic [htrd_pkg::IDX_W-1:0] idx);
            if (idx >= NODE_DEPTH) return '0;
            return node_mem[idx];
        endfunction

        // A full table or a full stack drops the node and marks the tree bad.
        function void push_node(logic [htrd_pkg::NODE_W-1:0] entry);
            if (nodes_used >= NODE_DEPTH || stack_top >= MAX_SYM)
            begin
                bad = 1;
                return;
            end
            node_mem[nodes_used] = entry;
            stack_mem[stack_top] = nodes_used[htrd_pkg::IDX_W-1:0];
            nodes_used++;
            stack_top++;
        endfunction

        function void tree_bit(logic b);
            logic [htrd_pkg::NODE_W-1:0] entry;
            entry = '0;
            if (in_leaf)
            begin
                leaf_sym = {leaf_sym[htrd_pkg::SYM_W-2:0], b};
                leaf_cnt++;
                if (leaf_cnt >= htrd_pkg::SYM_W)
                begin
                    entry[htrd_pkg::LEAF_BIT]    = 1'b1;
                    entry[htrd_pkg::SYM_W-1:0]   = leaf_sym;
                    push_node(entry);
                    in_leaf  = 0;
                    leaf_cnt = 0;
                    leaf_sym = '0;
                end
            end
            else if (b)
            begin
                in_leaf  = 1;
                leaf_cnt = 0;
                leaf_sym = '0;
            end
            else if (stack_top == 1)
            begin
                complete = 1;
                walk     = stack_mem[0];
            end
            else if (stack_top == 0)
                bad = 1;
            else
            begin
                entry[2*htrd_pkg::IDX_W-1:htrd_pkg::IDX_W] = stack_mem[stack_top-2];
                entry[htrd_pkg::IDX_W-1:0]                 = stack_mem[stack_top-1];
                stack_top -= 2;
                push_node(entry);
            end
        endfunction

        // Note an accepted request and queue the symbols it decodes to.
        function void take_byte(htrd_pkg::in_t req);
            htrd_pkg::out_t              syms [htrd_pkg::SYM_W];
            int                          n;
            logic [htrd_pkg::NODE_W-1:0] cur;
            logic [htrd_pkg::NODE_W-1:0] ent;
            logic [htrd_pkg::IDX_W-1:0]  child;
            n = 0;
            if (bad) return;
            if (req.op == htrd_pkg::OP_TREE)
            begin
                // Bits after the completing zero are ignored, and so are later tree bytes.
                for (int i = htrd_pkg::SYM_W - 1; i >= 0; i--)
                begin
                    if (complete || bad) break;
                    tree_bit(req.byte_in[i]);
                end
                return;
            end
            if (!complete) return;
            for (int i = htrd_pkg::SYM_W - 1; i >= 0; i--)
            begin
                if (emitted >= limit) break;
                cur = read_node(walk);
                // A lone leaf at the root is unreachable, so nothing decodes.
                if (cur[htrd_pkg::LEAF_BIT]) continue;
                child = req.byte_in[i] ? cur[htrd_pkg::IDX_W-1:0]
                                       : cur[2*htrd_pkg::IDX_W-1:htrd_pkg::IDX_W];
                ent   = read_node(child);
                if (ent[htrd_pkg::LEAF_BIT])
                begin
                    emitted++;
                    syms[n].symbol   = ent[htrd_pkg::SYM_W-1:0];
                    syms[n].last     = 1'b0;
                    syms[n].done_res = (emitted == limit);
                    n++;
                    walk = stack_mem[0];
                end
                else
                    walk = child;
            end
            if (n > 0) syms[n-1].last = 1'b1;
            for (int j = 0; j < n; j++) pending.push_back(syms[j]);
        endfunction

        function void write_reg(logic [htrd_pkg::ADDR_W-1:0] addr,
                                logic [htrd_pkg::DATA_W-1:0] value);
            if (addr[2] == htrd_pkg::REG_OUT_LENGTH) limit = value;
        endfunction

        // Compare a received symbol request with the oldest one queued.
        function void match_symbol(htrd_pkg::out_t got);
            htrd_pkg::out_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected symbol request, expected none, got %02h last %0b done %0b",
                         $time, got.symbol, got.last, got.done_res);
                return;
            end
            want = pending.pop_front();
            if (got.symbol !== want.symbol)
            begin
                errors++;
                $display("%0t: symbol mismatch, expected %02h, got %02h",
                         $time, want.symbol, got.symbol);
            end
            if (got.last !== want.last)
            begin
                errors++;
                $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
            end
            if (got.done_res !== want.done_res)
            begin
                errors++;
                $display("%0t: done_res mismatch, expected %0b, got %0b",
                         $time, want.done_res, got.done_res);
            end
        endfunction
    endclass

    huffman_shadow shadow;
    bit            tree_stream [$];
    int            tx_idle_max = 6;
    int            rx_idle_max = 6;
    int            hold_cycles = 0;
    int            quiet_cycles = 0;

    huffman_tree_rebuild_and_decode_top #(
        .MAX_SYMBOLS (MAX_SYM)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watch both channels and the register port at every edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) shadow.match_symbol(out_data);
            if (in_valid && in_ready) shadow.take_byte(in_data);
            if (psel && penable && pwrite && pready) shadow.write_reg(paddr, pwdata);
        end
    end

    // Give up when no request moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls per symbol, plus one long hold-off on request.
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, rx_idle_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(input htrd_pkg::in_t req);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending, wait until every queued symbol has come, then let the block settle.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (shadow.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [htrd_pkg::ADDR_W-1:0] addr,
                             input logic [htrd_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random post-order tree with the extreme symbols first, padded to whole bytes.
    function automatic void make_tree(input int leaves);
        int                         placed;
        int                         on_stack;
        logic [htrd_pkg::SYM_W-1:0] sym;
        placed   = 0;
        on_stack = 0;
        tree_stream.delete();
        while (placed < leaves || on_stack > 1)
        begin
            if (placed < leaves && (on_stack < 2 || $urandom_range(0, 2) != 0))
            begin
                sym = (placed == 0) ? 8'h00 : (placed == 1) ? 8'hFF
                                                            : htrd_pkg::SYM_W'($urandom);
                tree_stream.push_back(1'b1);
                for (int i = htrd_pkg::SYM_W - 1; i >= 0; i--) tree_stream.push_back(sym[i]);
                placed++;
                on_stack++;
            end
            else
            begin
                tree_stream.push_back(1'b0);
                on_stack--;
            end
        end
        tree_stream.push_back(1'b0);
        while (tree_stream.size() % htrd_pkg::SYM_W != 0) tree_stream.push_back(1'($urandom));
    endfunction

    function automatic logic [htrd_pkg::SYM_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return htrd_pkg::SYM_W'($urandom);
        endcase
    endfunction

    initial
    begin
        htrd_pkg::in_t              req;
        logic [htrd_pkg::CNT_W-1:0] new_length;
        int                         n_items;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        shadow = new();
        make_tree(TREE_LEAVES);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Data before the tree is complete is dropped.
        req.op      = htrd_pkg::OP_DATA;
        req.byte_in = 8'hA5;
        send_request(req);

        // The tree itself; the completing byte may carry ignored padding bits.
        req.op = htrd_pkg::OP_TREE;
        for (int b = 0; b < tree_stream.size(); b += htrd_pkg::SYM_W)
        begin
            for (int i = 0; i < htrd_pkg::SYM_W; i++)
                req.byte_in[htrd_pkg::SYM_W-1-i] = tree_stream[b+i];
            send_request(req);
        end

        // Tree bytes after completion are ignored, even one that would underflow the stack.
        req.byte_in = 8'hFF;
        send_request(req);
        req.byte_in = 8'h00;
        send_request(req);

        // With the length still at its reset value of zero, nothing is emitted.
        req.op      = htrd_pkg::OP_DATA;
        req.byte_in = 8'h3C;
        send_request(req);
        settle();

        // A short length makes the count run out partway through these bytes.
        write_reg(ADDR_OUT_LENGTH, 32'd3);
        req.byte_in = 8'h00;
        send_request(req);
        req.byte_in = 8'hFF;
        send_request(req);
        req.byte_in = 8'h5A;
        send_request(req);
        req.byte_in = 8'hC3;
        send_request(req);
        settle();

        // A write to the unused slot leaves the length alone.
        write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
        req.byte_in = 8'h96;
        send_request(req);
        settle();

        // Random phases, each with its own length and idle pattern.
        for (int p = 0; p < 6; p++)
        begin
            n_items = 24;
            case (p)
                0:
                begin
                    new_length  = shadow.emitted + $urandom_range(20, 60);
                    tx_idle_max = 6;
                    rx_idle_max = 6;
                end
                1:
                begin
                    new_length  = shadow.emitted + $urandom_range(20, 60);
                    tx_idle_max = 0;
                    rx_idle_max = 0;
                end
                2:
                begin
                    new_length  = shadow.emitted + $urandom_range(30, 60);
                    tx_idle_max = 0;
                    rx_idle_max = 3;
                    hold_cycles = HOLD_STRETCH;
                end
                3:
                begin
                    new_length  = '0;
                    n_items     = 6;
                    tx_idle_max = 2;
                    rx_idle_max = 2;
                end
                4:
                begin
                    new_length  = shadow.emitted + $urandom_range(20, 60);
                    tx_idle_max = 0;
                    rx_idle_max = 6;
                end
                default:
                begin
                    new_length  = 32'hFFFF_FFFF;
                    n_items     = 40;
                    tx_idle_max = 6;
                    rx_idle_max = 1;
                end
            endcase
            write_reg(ADDR_OUT_LENGTH, new_length);
            repeat (n_items)
            begin
                req.op      = ($urandom_range(0, 6) == 0) ? htrd_pkg::OP_TREE
                                                          : htrd_pkg::OP_DATA;
                req.byte_in = pick_byte();
                send_request(req);
            end
            settle();
        end

        if (shadow.errors == 0 && shadow.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
